### rtl/crc32_msb_first_case_fold_unit_defines.svh
// ----------------------------------------------------------------------------
// crc32_msb_first_case_fold_unit_defines.svh
// Assertion macros for the CRC-32 case-fold unit. Define ASSERT_OFF to drop
// every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef CRC32_MSB_FIRST_CASE_FOLD_UNIT_DEFINES_SVH
`define CRC32_MSB_FIRST_CASE_FOLD_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define CRCF_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("crcf assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CRCF_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("crcf assertion failed");

`else

`define CRCF_ASSERT_IMPL(label, clk, rstn, pre, post)
`define CRCF_ASSERT_NEXT(label, clk, rstn, pre, post)

`endif

`endif

### rtl/crcf_pkg.sv
// ----------------------------------------------------------------------------
// crcf_pkg
// Shared constants and the byte-step function of the MSB-first CRC-32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crcf_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned AddrWidth = 2;
    localparam int unsigned DataWidth = 32;

    localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;

    localparam logic [ByteWidth-1:0] AsciiLowerA = 8'h61;
    localparam logic [ByteWidth-1:0] AsciiLowerZ = 8'h7A;
    localparam logic [ByteWidth-1:0] AsciiCaseGap = 8'h20;

    // Register word index of the fold_case control bit.
    localparam logic [AddrWidth-1:0] RegFoldCase = 2'd0;

    typedef logic [CrcWidth-1:0]  crc_t;
    typedef logic [ByteWidth-1:0] byte_t;

    // CRC of one byte placed in the top byte of the register (table entry).
    function automatic crc_t crc_byte_term(input byte_t idx);
        crc_t r;
        r = {idx, {(CrcWidth-ByteWidth){1'b0}}};
        for (int k = 0; k < ByteWidth; k++) begin
            if (r[CrcWidth-1]) begin
                r = {r[CrcWidth-2:0], 1'b0} ^ CrcPoly;
            end else begin
                r = {r[CrcWidth-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Fold one byte into the running CRC.
    function automatic crc_t crc_byte_step(input crc_t crc, input byte_t data);
        return {crc[CrcWidth-ByteWidth-1:0], {ByteWidth{1'b0}}}
            ^ crc_byte_term(data ^ crc[CrcWidth-1 -: ByteWidth]);
    endfunction

endpackage

`default_nettype wire

### rtl/crcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// crcf_cfg_regs
// APB-style control register holding the fold_case bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcf_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crcf_pkg::AddrWidth-1:0] paddr,
    input  wire logic [crcf_pkg::DataWidth-1:0] pwdata,
    output logic      [crcf_pkg::DataWidth-1:0] prdata,
    output logic                               pready,
    output logic                               fold_case
);
    import crcf_pkg::*;

    logic fold_case_reg;
    logic wr_en;

    // Single word; every address in the port's range maps to it.
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_case_reg <= 1'b0;
        end else if (wr_en) begin
            fold_case_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr)
            RegFoldCase: prdata = {{(DataWidth-1){1'b0}}, fold_case_reg};
            default:     prdata = {{(DataWidth-1){1'b0}}, fold_case_reg};
        endcase
    end

    assign pready    = 1'b1;
    assign fold_case = fold_case_reg;

endmodule

`default_nettype wire

### rtl/crcf_update.sv
// ----------------------------------------------------------------------------
// crcf_update
// Case folding and one-byte CRC-32 update between the two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcf_update (
    input  wire logic                fold_case,
    input  wire logic                first,
    input  wire crcf_pkg::byte_t     data_byte,
    input  wire crcf_pkg::crc_t      crc_in,
    output crcf_pkg::crc_t           crc_out
);
    import crcf_pkg::*;

    byte_t data_folded;
    crc_t  crc_start;

    always_comb begin
        data_folded = data_byte;
        if (fold_case && (data_byte inside {[AsciiLowerA:AsciiLowerZ]})) begin
            data_folded = data_byte - AsciiCaseGap;
        end
    end

    // Restart from zero on the first byte of a message.
    assign crc_start = first ? '0 : crc_in;
    assign crc_out   = crc_byte_step(crc_start, data_folded);

endmodule

`default_nettype wire

### rtl/crc32_msb_first_case_fold_unit.sv
// ----------------------------------------------------------------------------
// crc32_msb_first_case_fold_unit
// Path: an accepted input byte is held in the input register, then its result
//   moves into the result register, which drives m_valid.
// Throughput: one byte per cycle while m_ready is high; the byte update is
//   a single pass of fixed XOR logic between the two registers.
// Reset: synchronous, active low; clears both valid flags, the running CRC
//   and fold_case.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "crc32_msb_first_case_fold_unit_defines.svh"

module crc32_msb_first_case_fold_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [crcf_pkg::AddrWidth-1:0] paddr,
    input  wire logic [crcf_pkg::DataWidth-1:0] pwdata,
    output logic      [crcf_pkg::DataWidth-1:0] prdata,
    output logic                                pready,
    // Input byte stream
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [crcf_pkg::ByteWidth-1:0] s_data_byte,
    input  wire logic                           s_first,
    // CRC results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [crcf_pkg::CrcWidth-1:0]  m_crc_value
);
    import crcf_pkg::*;

    logic  fold_case;

    // Input stage: holds one accepted byte until the update can run.
    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_byte_reg;
    logic  in_first_reg;

    // Result stage and running CRC.
    logic  out_valid_reg;
    logic  out_valid_next;
    crc_t  out_crc_reg;
    crc_t  crc_reg;
    crc_t  crc_next;

    logic  s_xfer;
    logic  advance;

    crcf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fold_case (fold_case)
    );

    crcf_update u_update (
        .fold_case (fold_case),
        .first     (in_first_reg),
        .data_byte (in_byte_reg),
        .crc_in    (crc_reg),
        .crc_out   (crc_next)
    );

    // Advance the held byte into the result register whenever that register
    // is empty or its transfer completes in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Accept a new byte when the input stage is empty or drains this cycle;
    // a waiting result blocks the next transfer only while the input stage is full.
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and running CRC.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                crc_reg <= crc_next;
            end
        end
    end

    // Payload registers: capture on transfer or advance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first;
        end
        if (advance) begin
            out_crc_reg <= crc_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;

    // A shown result is always the latest running CRC.
    `CRCF_ASSERT_IMPL(a_out_matches_state, aclk, aresetn, out_valid_reg, out_crc_reg == crc_reg)
    // A held byte is never dropped while the result side stalls.
    `CRCF_ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    // Both stages full and stalled: no new transfer may be taken.
    `CRCF_ASSERT_IMPL(a_full_blocks, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready, !s_ready)

endmodule

`default_nettype wire
